[sv/llc_pkg.sv]
`default_nettype none
package llc_pkg;

    // angle ranges, degrees with 16 fraction bits
    localparam int TURN_Q16    = 23592960;
    localparam int HALF_Q16    = 11796480;
    localparam int QUARTER_Q16 = 5898240;

    // widths
    localparam int ANG_W   = 26;
    localparam int RED_W   = 28;
    localparam int MAG_W   = 23;
    localparam int THETA_W = 44;
    localparam int XY_W    = 36;
    localparam int TRIG_W  = 32;
    localparam int RAD_W   = 25;
    localparam int RH_W    = 27;
    localparam int PROD_W  = 64;
    localparam int OUT_W   = 26;
    localparam int OUT_LIMIT = 18874368;
    localparam int RADIUS_RESET = 6520289;

    // degrees-to-radians scaling: divide by 45 * 2^16
    localparam int DEG_SHIFT  = 16;
    localparam int DEG_ROUND  = 1474560;
    localparam int DIV_CONST  = 45;
    localparam longint unsigned DEG_DIV = 64'(DIV_CONST) << DEG_SHIFT;
    // pi/4 split as quotient and remainder of the divisor
    localparam int KQ_W       = 20;
    localparam int KR_W       = 22;
    localparam int PA_W       = MAG_W + KQ_W;
    localparam int PB_W       = MAG_W + KR_W + 1;
    // remainder part after the 2^16 shift stays below 2^Y_W
    localparam int Y_W        = 28;
    localparam int REC_SHIFT  = Y_W + 6;
    localparam int REC_MUL_W  = 29;
    localparam int REC_W      = Y_W + REC_MUL_W;
    localparam int QUO_W      = REC_W - REC_SHIFT;
    // reduce, multiply, round, reciprocal multiply, sum and sign
    localparam int ANG_LAT    = 5;

    // unsigned long division by shift and subtract
    function automatic longint unsigned llc_udiv(input longint unsigned n,
                                                 input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned llc_isqrt(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // atan(1/m) in Q60
    function automatic longint unsigned llc_atan_inv_q60(input longint unsigned m);
        longint unsigned p;
        longint unsigned sum;
        longint unsigned k;
        p = llc_udiv(64'd1 << 60, m);
        sum = p;
        k = 1;
        while (p != 0)
        begin
            p = llc_udiv(p, m * m);
            if (k[0])
                sum = sum - llc_udiv(p, 2 * k + 1);
            else
                sum = sum + llc_udiv(p, 2 * k + 1);
            k = k + 1;
        end
        return sum;
    endfunction

    // atan(2^-i) in Q60
    function automatic longint unsigned llc_atan_pow2_q60(input int i);
        longint unsigned sum;
        longint unsigned term;
        int k;
        int n;
        sum = 0;
        k = 0;
        n = i;
        while (n < 60)
        begin
            term = llc_udiv(64'd1 << (60 - n), longint'(2 * k + 1));
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
            k = k + 1;
            n = i * (2 * k + 1);
        end
        return sum;
    endfunction

    // rotation angle table, Q40 radians; entry 0 is pi/4
    function automatic longint unsigned llc_atan_q40(input int i);
        longint unsigned v;
        if (i == 0)
            v = 4 * llc_atan_inv_q60(5) - llc_atan_inv_q60(239);
        else
            v = llc_atan_pow2_q60(i);
        return (v + (64'd1 << 19)) >> 20;
    endfunction

    // CORDIC start magnitude, Q32
    function automatic longint unsigned llc_gain_q32(input int stages);
        longint unsigned g;
        longint unsigned s;
        g = 64'd1 << 32;
        for (int i = 0; i < stages && i < 32; i++)
        begin
            if (2 * i <= 60)
                s = llc_isqrt((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
            else
                s = 64'd1 << 30;
            g = llc_udiv((g << 30) + (s >> 1), s);
        end
        return g;
    endfunction

    localparam longint unsigned PI4_Q40 = llc_atan_q40(0);
    localparam logic [KQ_W-1:0] PI4_QUO = KQ_W'(llc_udiv(PI4_Q40, DEG_DIV));
    localparam logic [KR_W-1:0] PI4_REM =
        KR_W'(PI4_Q40 - llc_udiv(PI4_Q40, DEG_DIV) * DEG_DIV);
    // ceil(2^REC_SHIFT / 45): exact floor division for inputs below 2^Y_W
    localparam logic [REC_MUL_W-1:0] REC_MUL =
        REC_MUL_W'(llc_udiv((64'd1 << REC_SHIFT) + 64'(DIV_CONST - 1), 64'(DIV_CONST)));

    // round half up from Q30, floor shift
    function automatic logic signed [PROD_W-1:0] llc_rnd30(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] s;
        s = v + (PROD_W'(1) <<< 29);
        return s >>> 30;
    endfunction

endpackage
`default_nettype wire

[sv/latlon_to_cartesian.sv]
// Channel   Direction  Handshake               Payload
// config    in         cfg_wr_en               cfg_wr_data (sphere radius)
// point     in         in_valid / in_stall     latitude, longitude, height
// result    out        out_valid / out_stall   coord_x, coord_y, coord_z
//
// One item per cycle sustained while out_stall does not hold a result; the path runs
// through the angle scaling (5 stages), one CORDIC stage per rotation and the scale stages.
// Reset clears all valid bits and loads the radius with 6367.47 km.
// When a result is held by out_stall the whole pipeline freezes; in_stall is
// raised for exactly those cycles, so nothing is lost or repeated.
`default_nettype none
module latlon_to_cartesian
    import llc_pkg::*;
#(
    parameter int CORDIC_STAGES = 20
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [RAD_W-1:0]         cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [23:0]       latitude,
    input  wire logic signed [ANG_W-1:0]  longitude,
    input  wire logic signed [21:0]       height,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [OUT_W-1:0]       coord_x,
    output logic signed [OUT_W-1:0]       coord_y,
    output logic signed [OUT_W-1:0]       coord_z
);

    localparam int RH_DLY = ANG_LAT + CORDIC_STAGES + 1;

    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // radius register
    logic [RAD_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RAD_W'(RADIUS_RESET);
        else if (cfg_wr_en)
            radius_reg <= cfg_wr_data;
    end

    // radius plus height, delayed to meet the trig results
    logic signed [RH_W-1:0] rh_next;
    logic signed [RH_W-1:0] rh_reg [0:RH_DLY-1];

    assign rh_next = signed'(RH_W'(radius_reg)) + RH_W'(height);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rh_reg[0] <= rh_next;
            for (int i = 1; i < RH_DLY; i++)
                rh_reg[i] <= rh_reg[i-1];
        end
    end

    // angle scaling
    logic                      lat_av;
    logic                      lon_av;
    logic signed [THETA_W-1:0] lat_th;
    logic signed [THETA_W-1:0] lon_th;
    logic                      lat_fl;
    logic                      lon_fl;

    llc_angle u_lat_angle (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .ang      (ANG_W'(latitude)),
        .out_valid(lat_av),
        .theta    (lat_th),
        .flip     (lat_fl)
    );

    llc_angle u_lon_angle (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .ang      (longitude),
        .out_valid(lon_av),
        .theta    (lon_th),
        .flip     (lon_fl)
    );

    // sine and cosine
    logic                     lat_cv;
    logic                     lon_cv;
    logic signed [TRIG_W-1:0] sin_lat;
    logic signed [TRIG_W-1:0] cos_lat;
    logic signed [TRIG_W-1:0] sin_lon;
    logic signed [TRIG_W-1:0] cos_lon;

    llc_cordic #(.STAGES(CORDIC_STAGES)) u_lat_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (lat_av),
        .theta    (lat_th),
        .flip     (lat_fl),
        .out_valid(lat_cv),
        .sin_q30  (sin_lat),
        .cos_q30  (cos_lat)
    );

    llc_cordic #(.STAGES(CORDIC_STAGES)) u_lon_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (lon_av),
        .theta    (lon_th),
        .flip     (lon_fl),
        .out_valid(lon_cv),
        .sin_q30  (sin_lon),
        .cos_q30  (cos_lon)
    );

    // products, rounding, saturation, output register
    llc_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (lat_cv && lon_cv),
        .sin_lat  (sin_lat),
        .cos_lat  (cos_lat),
        .sin_lon  (sin_lon),
        .cos_lon  (cos_lon),
        .rh       (rh_reg[RH_DLY-1]),
        .out_valid(out_valid),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .coord_z  (coord_z)
    );

    // checks
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("pipeline not frozen on held result");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        lat_cv == lon_cv)
        else $error("trig lanes out of step");

    a_xlim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (coord_x <= OUT_W'(OUT_LIMIT)) && (coord_x >= -OUT_W'(OUT_LIMIT)))
        else $error("coord_x beyond limit");

    a_zlim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (coord_z <= OUT_W'(OUT_LIMIT)) && (coord_z >= -OUT_W'(OUT_LIMIT)))
        else $error("coord_z beyond limit");

endmodule
`default_nettype wire

[sv/llc_angle.sv]
`default_nettype none
module llc_angle
    import llc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic signed [ANG_W-1:0]   ang,
    output logic                           out_valid,
    output logic signed [THETA_W-1:0]      theta,
    output logic                           flip
);

    // stage 1: reduce to [-90, 90] degrees
    logic signed [RED_W-1:0] v;
    logic signed [RED_W-1:0] m;
    logic signed [RED_W-1:0] t;
    logic signed [RED_W-1:0] t_abs;
    logic                    flip_next;
    logic                    v1_reg;
    logic [MAG_W-1:0]        mag1_reg;
    logic                    neg1_reg;
    logic                    flip1_reg;

    always_comb
    begin
        v = RED_W'(ang);
        if (v < -RED_W'(TURN_Q16))
            m = v + RED_W'(2 * TURN_Q16);
        else if (v < 0)
            m = v + RED_W'(TURN_Q16);
        else if (v >= RED_W'(TURN_Q16))
            m = v - RED_W'(TURN_Q16);
        else
            m = v;
        flip_next = 1'b0;
        if (m <= RED_W'(QUARTER_Q16))
            t = m;
        else if (m < RED_W'(3 * QUARTER_Q16))
        begin
            t = m - RED_W'(HALF_Q16);
            flip_next = 1'b1;
        end
        else
            t = m - RED_W'(TURN_Q16);
        t_abs = (t < 0) ? -t : t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= t_abs[MAG_W-1:0];
            neg1_reg  <= t[RED_W-1];
            flip1_reg <= flip_next;
        end
    end

    // stage 2: magnitude times quotient and remainder parts of pi/4
    logic            v2_reg;
    logic [PA_W-1:0] pa2_reg;
    logic [PB_W-1:0] pb2_reg;
    logic            neg2_reg;
    logic            flip2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa2_reg   <= PA_W'(mag1_reg) * PA_W'(PI4_QUO);
            pb2_reg   <= PB_W'(mag1_reg) * PB_W'(PI4_REM);
            neg2_reg  <= neg1_reg;
            flip2_reg <= flip1_reg;
        end
    end

    // stage 3: round the remainder part, drop the 2^16 part of the divisor
    logic [PB_W-1:0] sumb3;
    logic            v3_reg;
    logic [Y_W-1:0]  y3_reg;
    logic [PA_W-1:0] pa3_reg;
    logic            neg3_reg;
    logic            flip3_reg;

    assign sumb3 = pb2_reg + PB_W'(DEG_ROUND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y3_reg    <= sumb3[DEG_SHIFT +: Y_W];
            pa3_reg   <= pa2_reg;
            neg3_reg  <= neg2_reg;
            flip3_reg <= flip2_reg;
        end
    end

    // stage 4: divide by 45 with a reciprocal multiply
    logic             v4_reg;
    logic [REC_W-1:0] rec4_reg;
    logic [PA_W-1:0]  pa4_reg;
    logic             neg4_reg;
    logic             flip4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec4_reg  <= REC_W'(y3_reg) * REC_W'(REC_MUL);
            pa4_reg   <= pa3_reg;
            neg4_reg  <= neg3_reg;
            flip4_reg <= flip3_reg;
        end
    end

    // final stage: add the parts, apply sign
    logic                       vo_reg;
    logic signed [THETA_W-1:0]  theta_reg;
    logic                       flipo_reg;
    logic signed [THETA_W-1:0]  q;

    assign q = THETA_W'(pa4_reg) + THETA_W'(rec4_reg[REC_SHIFT +: QUO_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg <= neg4_reg ? -q : q;
            flipo_reg <= flip4_reg;
        end
    end

    assign out_valid = vo_reg;
    assign theta     = theta_reg;
    assign flip      = flipo_reg;

endmodule
`default_nettype wire

[sv/llc_cordic.sv]
`default_nettype none
module llc_cordic
    import llc_pkg::*;
#(
    parameter int STAGES = 20
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic signed [THETA_W-1:0] theta,
    input  wire logic                      flip,
    output logic                           out_valid,
    output logic signed [TRIG_W-1:0]       sin_q30,
    output logic signed [TRIG_W-1:0]       cos_q30
);

    localparam logic signed [XY_W-1:0] GAIN = XY_W'(llc_gain_q32(STAGES));

    // stage inputs; index 0 is the start vector
    logic signed [XY_W-1:0]    cx  [0:STAGES];
    logic signed [XY_W-1:0]    cy  [0:STAGES];
    logic signed [THETA_W-1:0] cth [0:STAGES];
    logic                      cv  [0:STAGES];
    logic                      cf  [0:STAGES];

    assign cx[0]  = GAIN;
    assign cy[0]  = '0;
    assign cth[0] = theta;
    assign cv[0]  = in_valid;
    assign cf[0]  = flip;

    // one rotation per stage
    for (genvar i = 0; i < STAGES; i++)
    begin : g_rot
        localparam logic signed [THETA_W-1:0] ATAN_I = THETA_W'(llc_atan_q40(i));
        logic signed [XY_W-1:0]    x_reg;
        logic signed [XY_W-1:0]    y_reg;
        logic signed [THETA_W-1:0] th_reg;
        logic                      v_reg;
        logic                      f_reg;
        logic signed [XY_W-1:0]    dx;
        logic signed [XY_W-1:0]    dy;

        assign dx = cy[i] >>> i;
        assign dy = cx[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (en)
                v_reg <= cv[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cth[i][THETA_W-1])
                begin
                    x_reg  <= cx[i] - dx;
                    y_reg  <= cy[i] + dy;
                    th_reg <= cth[i] - ATAN_I;
                end
                else
                begin
                    x_reg  <= cx[i] + dx;
                    y_reg  <= cy[i] - dy;
                    th_reg <= cth[i] + ATAN_I;
                end
                f_reg <= cf[i];
            end
        end

        assign cx[i+1]  = x_reg;
        assign cy[i+1]  = y_reg;
        assign cth[i+1] = th_reg;
        assign cv[i+1]  = v_reg;
        assign cf[i+1]  = f_reg;
    end

    // round Q32 to Q30 and undo the half-turn fold
    logic signed [XY_W-1:0]   xr;
    logic signed [XY_W-1:0]   yr;
    logic                     vo_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    assign xr = (cx[STAGES] + XY_W'(2)) >>> 2;
    assign yr = (cy[STAGES] + XY_W'(2)) >>> 2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= cv[STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cf[STAGES] ? -xr[TRIG_W-1:0] : xr[TRIG_W-1:0];
            sin_reg <= cf[STAGES] ? -yr[TRIG_W-1:0] : yr[TRIG_W-1:0];
        end
    end

    assign out_valid = vo_reg;
    assign sin_q30   = sin_reg;
    assign cos_q30   = cos_reg;

    // cth is only read to steer; keep it used at the tail
    logic unused_th;
    assign unused_th = cth[STAGES][0];

endmodule
`default_nettype wire

[sv/llc_scale.sv]
`default_nettype none
module llc_scale
    import llc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic signed [TRIG_W-1:0] sin_lat,
    input  wire logic signed [TRIG_W-1:0] cos_lat,
    input  wire logic signed [TRIG_W-1:0] sin_lon,
    input  wire logic signed [TRIG_W-1:0] cos_lon,
    input  wire logic signed [RH_W-1:0]   rh,
    output logic                          out_valid,
    output logic signed [OUT_W-1:0]       coord_x,
    output logic signed [OUT_W-1:0]       coord_y,
    output logic signed [OUT_W-1:0]       coord_z
);

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        r = v;
        if (r > PROD_W'(OUT_LIMIT))
            r = PROD_W'(OUT_LIMIT);
        if (r < -PROD_W'(OUT_LIMIT))
            r = -PROD_W'(OUT_LIMIT);
        return r[OUT_W-1:0];
    endfunction

    // stage 1: horizontal factors
    logic                     v1_reg;
    logic signed [PROD_W-1:0] pcc1_reg;
    logic signed [PROD_W-1:0] pcs1_reg;
    logic signed [TRIG_W-1:0] sp1_reg;
    logic signed [RH_W-1:0]   rh1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcc1_reg <= PROD_W'(cos_lat) * PROD_W'(cos_lon);
            pcs1_reg <= PROD_W'(cos_lat) * PROD_W'(sin_lon);
            sp1_reg  <= sin_lat;
            rh1_reg  <= rh;
        end
    end

    // stage 2: round factors to Q30, scale by radius plus height
    logic                     v2_reg;
    logic signed [PROD_W-1:0] px2_reg;
    logic signed [PROD_W-1:0] py2_reg;
    logic signed [PROD_W-1:0] pz2_reg;
    logic signed [PROD_W-1:0] fx;
    logic signed [PROD_W-1:0] fy;

    assign fx = llc_rnd30(pcc1_reg);
    assign fy = llc_rnd30(pcs1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px2_reg <= PROD_W'(rh1_reg) * PROD_W'(signed'(fx[TRIG_W-1:0]));
            py2_reg <= PROD_W'(rh1_reg) * PROD_W'(signed'(fy[TRIG_W-1:0]));
            pz2_reg <= PROD_W'(rh1_reg) * PROD_W'(sp1_reg);
        end
    end

    // stage 3: round, saturate, output register
    logic                    v3_reg;
    logic signed [OUT_W-1:0] x3_reg;
    logic signed [OUT_W-1:0] y3_reg;
    logic signed [OUT_W-1:0] z3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x3_reg <= sat(llc_rnd30(px2_reg));
            y3_reg <= sat(llc_rnd30(py2_reg));
            z3_reg <= sat(llc_rnd30(pz2_reg));
        end
    end

    assign out_valid = v3_reg;
    assign coord_x   = x3_reg;
    assign coord_y   = y3_reg;
    assign coord_z   = z3_reg;

endmodule
`default_nettype wire
